// ----- sv/stt_pkg.sv -----
// Shared types, codes and keyword tables for the source text tokenizer.
// Used by every module of the block; depends on nothing else.
package stt_pkg;

  localparam int KW_MAX_LEN    = 6;                        // word bytes kept for matching
  localparam int KW_TEXT_BYTES = 6;                        // longest keyword
  localparam int KW_COUNT      = 16;
  localparam int WLEN_W        = $clog2(KW_MAX_LEN + 2);   // holds 0 .. KW_MAX_LEN + 1
  localparam int WIDX_W        = $clog2(KW_MAX_LEN);
  localparam int MAX_RES       = 3;                        // results per item
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  typedef logic [5:0] tt_t;
  typedef logic [KW_MAX_LEN-1:0][7:0] wbuf_t;
  typedef logic [8*KW_TEXT_BYTES-1:0] kw_text_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_OP     = 3'd1,
    MODE_INT    = 3'd2,
    MODE_FRAC   = 3'd3,
    MODE_WORD   = 3'd4,
    MODE_STRING = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    PEND_EQ   = 2'd0,
    PEND_GT   = 2'd1,
    PEND_LT   = 2'd2,
    PEND_BANG = 2'd3
  } pend_e;

  localparam tt_t TT_IDENT   = 6'd0;
  localparam tt_t TT_NUMBER  = 6'd1;
  localparam tt_t TT_STRING  = 6'd2;
  localparam tt_t TT_PLUS    = 6'd3;
  localparam tt_t TT_STAR    = 6'd4;
  localparam tt_t TT_MINUS   = 6'd5;
  localparam tt_t TT_SLASH   = 6'd6;
  localparam tt_t TT_PERCENT = 6'd7;
  localparam tt_t TT_LPAREN  = 6'd8;
  localparam tt_t TT_RPAREN  = 6'd9;
  localparam tt_t TT_SEMI    = 6'd10;
  localparam tt_t TT_COMMA   = 6'd11;
  localparam tt_t TT_EQ      = 6'd12;   // two-char form is one above, then pairs
  localparam tt_t TT_BOOLEAN = 6'd24;

  localparam logic ERR_UNSUPPORTED  = 1'b0;
  localparam logic ERR_UNTERMINATED = 1'b1;

  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;

  // Keyword text right-aligned, zero-padded on the left.
  localparam kw_text_t KW_TEXT [KW_COUNT] = '{
    kw_text_t'("print"), kw_text_t'("do"),   kw_text_t'("end"),    kw_text_t'("let"),
    kw_text_t'("true"),  kw_text_t'("false"), kw_text_t'("and"),   kw_text_t'("or"),
    kw_text_t'("null"),  kw_text_t'("if"),   kw_text_t'("else"),   kw_text_t'("elseif"),
    kw_text_t'("then"),  kw_text_t'("while"), kw_text_t'("fn"),    kw_text_t'("return")
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd5, 3'd2, 3'd3, 3'd3, 3'd4, 3'd5, 3'd3, 3'd2,
    3'd4, 3'd2, 3'd4, 3'd6, 3'd4, 3'd5, 3'd2, 3'd6
  };
  localparam tt_t KW_CODE [KW_COUNT] = '{
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd24, 6'd25, 6'd26,
    6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34
  };

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } stt_in_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_value;
    tt_t        tok_id;
    logic       bool_value;
    logic       error_code;
    logic       last;
  } stt_out_t;

  // All results of one item, front to back.
  typedef struct packed {
    logic [1:0]                count;
    stt_out_t [MAX_RES-1:0]    res;
  } stt_group_t;

  typedef struct packed {
    tt_t  tok_id;
    logic bool_value;
  } kw_hit_t;

  function automatic stt_out_t mk_res(kind_e kind, logic [7:0] b, tt_t t,
                                      logic bv, logic ec);
    stt_out_t r;
    r.kind       = kind;
    r.byte_value = b;
    r.tok_id     = t;
    r.bool_value = bv;
    r.error_code = ec;
    r.last       = 1'b0;
    return r;
  endfunction

  // Match the buffered word against the keyword list; identifier otherwise.
  function automatic kw_hit_t kw_lookup(wbuf_t w, logic [WLEN_W-1:0] len);
    kw_text_t acc;
    kw_hit_t  hit;
    logic     found;
    acc   = '0;
    hit   = '{tok_id: TT_IDENT, bool_value: 1'b0};
    found = 1'b0;
    for (int i = 0; i < KW_TEXT_BYTES; i++) begin
      if (i < len && i < KW_MAX_LEN) begin
        acc = {acc[8*KW_TEXT_BYTES-9:0], w[i]};
      end
    end
    if (len <= KW_MAX_LEN) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if (!found && len == WLEN_W'(KW_LEN[k]) && acc == KW_TEXT[k]) begin
          found          = 1'b1;
          hit.tok_id     = KW_CODE[k];
          hit.bool_value = (KW_CODE[k] == TT_BOOLEAN) && (KW_LEN[k] == 3'd4);
        end
      end
    end
    return hit;
  endfunction

endpackage

// ----- sv/stt_front.sv -----
// Front part: accepts source bytes, runs the scanner state and builds
// the group of up to three results of each item. Depends on stt_pkg.
module stt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  stt_pkg::stt_in_t    in_data_i,
  output logic                push_o,
  output stt_pkg::stt_group_t push_data_o
);

  stt_pkg::mode_e                   mode_q, mode_d;
  stt_pkg::pend_e                   pend_q, pend_d;
  logic [stt_pkg::WLEN_W-1:0]       wlen_q, wlen_d;
  logic                             err_q, err_d;
  stt_pkg::wbuf_t                   wbuf_q, wbuf_d;
  stt_pkg::stt_group_t              grp;
  stt_pkg::kw_hit_t                 kw;
  logic [1:0]                       n;
  logic                             hit;
  logic                             rescan;
  logic [7:0]                       c;
  logic                             eot;

  assign c   = in_data_i.char_byte;
  assign eot = in_data_i.end_of_text;

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b == stt_pkg::CH_SPACE || (b >= stt_pkg::CH_TAB && b <= stt_pkg::CH_CR);
  endfunction

  always_comb begin
    mode_d = mode_q;
    pend_d = pend_q;
    wlen_d = wlen_q;
    err_d  = err_q;
    wbuf_d = wbuf_q;
    grp    = '0;
    n      = 2'd0;
    hit    = 1'b0;
    rescan = 1'b0;
    kw     = '0;

    if (accept_i && !err_q) begin
      rescan = 1'b1;
      // end or extend the token in progress
      unique case (mode_q)
        stt_pkg::MODE_OP: begin
          mode_d = stt_pkg::MODE_IDLE;
          pend_d = stt_pkg::PEND_EQ;
          if (c == stt_pkg::CH_EQ) begin
            grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'd0,
                           stt_pkg::TT_EQ + {3'd0, pend_q, 1'b1}, 1'b0, 1'b0);
            n      = n + 2'd1;
            rescan = 1'b0;
          end else begin
            grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'd0,
                           stt_pkg::TT_EQ + {3'd0, pend_q, 1'b0}, 1'b0, 1'b0);
            n = n + 2'd1;
          end
        end
        stt_pkg::MODE_INT, stt_pkg::MODE_FRAC: begin
          if (is_digit(c) || (c == stt_pkg::CH_DOT && mode_q == stt_pkg::MODE_INT)) begin
            grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_BYTE, c, stt_pkg::TT_IDENT,
                                         1'b0, 1'b0);
            n      = n + 2'd1;
            rescan = 1'b0;
            if (c == stt_pkg::CH_DOT) mode_d = stt_pkg::MODE_FRAC;
          end else begin
            grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'd0, stt_pkg::TT_NUMBER,
                                         1'b0, 1'b0);
            n      = n + 2'd1;
            mode_d = stt_pkg::MODE_IDLE;
          end
        end
        stt_pkg::MODE_WORD: begin
          if (is_alpha(c) || is_digit(c) || c == stt_pkg::CH_UNDER) begin
            if (wlen_q < stt_pkg::KW_MAX_LEN) wbuf_d[wlen_q[stt_pkg::WIDX_W-1:0]] = c;
            // saturate one past the limit: too long for any keyword
            if (wlen_q <= stt_pkg::KW_MAX_LEN) wlen_d = wlen_q + stt_pkg::WLEN_W'(1);
            grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_BYTE, c, stt_pkg::TT_IDENT,
                                         1'b0, 1'b0);
            n      = n + 2'd1;
            rescan = 1'b0;
          end else begin
            kw         = stt_pkg::kw_lookup(wbuf_q, wlen_q);
            grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'd0, kw.tok_id,
                                         kw.bool_value, 1'b0);
            n      = n + 2'd1;
            mode_d = stt_pkg::MODE_IDLE;
            wlen_d = '0;
          end
        end
        stt_pkg::MODE_STRING: begin
          rescan = 1'b0;
          if (c == stt_pkg::CH_QUOTE) begin
            grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'd0, stt_pkg::TT_STRING,
                                         1'b0, 1'b0);
            mode_d = stt_pkg::MODE_IDLE;
          end else if (c == stt_pkg::CH_NEWLINE) begin
            grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_ERROR, 8'd0, stt_pkg::TT_IDENT,
                                         1'b0, stt_pkg::ERR_UNTERMINATED);
            hit = 1'b1;
          end else begin
            grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_BYTE, c, stt_pkg::TT_IDENT,
                                         1'b0, 1'b0);
          end
          n = n + 2'd1;
        end
        stt_pkg::MODE_IDLE: ;
        default: mode_d = stt_pkg::MODE_IDLE;
      endcase

      // scan the byte from idle
      if (rescan) begin
        priority if (is_space(c)) begin
        end else if (c == stt_pkg::CH_PLUS) begin
          grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'd0, stt_pkg::TT_PLUS, 1'b0, 1'b0);
          n = n + 2'd1;
        end else if (c == stt_pkg::CH_STAR) begin
          grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'd0, stt_pkg::TT_STAR, 1'b0, 1'b0);
          n = n + 2'd1;
        end else if (c == stt_pkg::CH_MINUS) begin
          grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'd0, stt_pkg::TT_MINUS, 1'b0, 1'b0);
          n = n + 2'd1;
        end else if (c == stt_pkg::CH_SLASH) begin
          grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'd0, stt_pkg::TT_SLASH, 1'b0, 1'b0);
          n = n + 2'd1;
        end else if (c == stt_pkg::CH_PERCENT) begin
          grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'd0, stt_pkg::TT_PERCENT,
                                       1'b0, 1'b0);
          n = n + 2'd1;
        end else if (c == stt_pkg::CH_LPAREN) begin
          grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'd0, stt_pkg::TT_LPAREN,
                                       1'b0, 1'b0);
          n = n + 2'd1;
        end else if (c == stt_pkg::CH_RPAREN) begin
          grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'd0, stt_pkg::TT_RPAREN,
                                       1'b0, 1'b0);
          n = n + 2'd1;
        end else if (c == stt_pkg::CH_SEMI) begin
          grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'd0, stt_pkg::TT_SEMI, 1'b0, 1'b0);
          n = n + 2'd1;
        end else if (c == stt_pkg::CH_COMMA) begin
          grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'd0, stt_pkg::TT_COMMA, 1'b0, 1'b0);
          n = n + 2'd1;
        end else if (c == stt_pkg::CH_EQ) begin
          mode_d = stt_pkg::MODE_OP;
          pend_d = stt_pkg::PEND_EQ;
        end else if (c == stt_pkg::CH_GT) begin
          mode_d = stt_pkg::MODE_OP;
          pend_d = stt_pkg::PEND_GT;
        end else if (c == stt_pkg::CH_LT) begin
          mode_d = stt_pkg::MODE_OP;
          pend_d = stt_pkg::PEND_LT;
        end else if (c == stt_pkg::CH_BANG) begin
          mode_d = stt_pkg::MODE_OP;
          pend_d = stt_pkg::PEND_BANG;
        end else if (c == stt_pkg::CH_QUOTE) begin
          mode_d = stt_pkg::MODE_STRING;
        end else if (is_digit(c)) begin
          grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_BYTE, c, stt_pkg::TT_IDENT, 1'b0, 1'b0);
          n      = n + 2'd1;
          mode_d = stt_pkg::MODE_INT;
        end else if (is_alpha(c)) begin
          wbuf_d[0]  = c;
          wlen_d     = stt_pkg::WLEN_W'(1);
          grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_BYTE, c, stt_pkg::TT_IDENT, 1'b0, 1'b0);
          n      = n + 2'd1;
          mode_d = stt_pkg::MODE_WORD;
        end else begin
          grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_ERROR, c, stt_pkg::TT_IDENT,
                                       1'b0, stt_pkg::ERR_UNSUPPORTED);
          n   = n + 2'd1;
          hit = 1'b1;
        end
      end

      // latch the error, or flush the pending token at end of text
      if (hit) begin
        err_d = 1'b1;
      end else if (eot) begin
        unique case (mode_d)
          stt_pkg::MODE_OP: begin
            grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'd0,
                           stt_pkg::TT_EQ + {3'd0, pend_d, 1'b0}, 1'b0, 1'b0);
            n = n + 2'd1;
          end
          stt_pkg::MODE_INT, stt_pkg::MODE_FRAC: begin
            grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'd0, stt_pkg::TT_NUMBER,
                                         1'b0, 1'b0);
            n = n + 2'd1;
          end
          stt_pkg::MODE_WORD: begin
            kw         = stt_pkg::kw_lookup(wbuf_d, wlen_d);
            grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'd0, kw.tok_id,
                                         kw.bool_value, 1'b0);
            n = n + 2'd1;
          end
          stt_pkg::MODE_STRING: begin
            grp.res[n] = stt_pkg::mk_res(stt_pkg::KIND_ERROR, 8'd0, stt_pkg::TT_IDENT,
                                         1'b0, stt_pkg::ERR_UNTERMINATED);
            n = n + 2'd1;
          end
          stt_pkg::MODE_IDLE: ;
          default: ;
        endcase
      end
    end

    // end of text returns the scanner to its reset state
    if (accept_i && eot) begin
      mode_d = stt_pkg::MODE_IDLE;
      pend_d = stt_pkg::PEND_EQ;
      wlen_d = '0;
      err_d  = 1'b0;
    end

    if (n != 2'd0) grp.res[n - 2'd1].last = 1'b1;
    grp.count = n;
  end

  assign push_o      = accept_i && (n != 2'd0);
  assign push_data_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= stt_pkg::MODE_IDLE;
      pend_q <= stt_pkg::PEND_EQ;
      wlen_q <= '0;
      err_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      wlen_q <= wlen_d;
      err_q  <= err_d;
    end
  end

  // word bytes are read only after being written in the same word
  always_ff @(posedge clk_i) begin
    wbuf_q <= wbuf_d;
  end

`ifndef ASSERT_OFF
  a_quiet_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> !push_o)
    else $error("results produced while discarding after an error");

  a_wlen_outside_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != stt_pkg::MODE_WORD |-> wlen_q == '0)
    else $error("word length left over outside a word");
`endif

endmodule

// ----- sv/stt_queue.sv -----
// Short queue of result groups between front and back parts.
// Depends on stt_pkg.
module stt_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  stt_pkg::stt_group_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output stt_pkg::stt_group_t data_o
);

  stt_pkg::stt_group_t               mem_q [stt_pkg::QDEPTH];
  logic [stt_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [stt_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [stt_pkg::QCNT_W-1:0]        count_q, count_d;

  assign full_o  = count_q == stt_pkg::QCNT_W'(stt_pkg::QDEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == stt_pkg::QPTR_W'(stt_pkg::QDEPTH - 1)) ? '0
                                                                    : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == stt_pkg::QPTR_W'(stt_pkg::QDEPTH - 1)) ? '0
                                                                    : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");
`endif

endmodule

// ----- sv/stt_back.sv -----
// Back part: takes result groups from the queue and sends their results
// one per cycle while the output is not stalled, through the output register. Depends on stt_pkg.
module stt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  stt_pkg::stt_group_t q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output stt_pkg::stt_out_t   out_data_o
);

  stt_pkg::stt_group_t cur_q, cur_d;
  logic                cur_valid_q, cur_valid_d;
  logic [1:0]          idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  stt_pkg::stt_out_t   out_q, out_d;
  logic                adv;
  logic                cur_done;

  assign adv      = !out_valid_q || !out_stall_i;
  assign cur_done = cur_valid_q && adv && (idx_q == cur_q.count - 2'd1);
  assign pop_o    = q_valid_i && (!cur_valid_q || cur_done);

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (adv) begin
      out_valid_d = cur_valid_q;
      out_d       = cur_q.res[idx_q];
      if (cur_valid_q) idx_d = cur_done ? 2'd0 : idx_q + 2'd1;
    end
    // refill from the queue as the current group runs out
    if (pop_o) begin
      cur_d       = q_data_i;
      cur_valid_d = 1'b1;
      idx_d       = 2'd0;
    end else if (cur_done) begin
      cur_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_group_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> q_data_i.count != 2'd0)
    else $error("empty result group taken from the queue");
`endif

endmodule

// ----- sv/source_text_tokenizer.sv -----
// Top level of the source text tokenizer: front scanner, group queue and
// result sender. Depends on stt_pkg, stt_front, stt_queue and stt_back.
//
//   channel  direction  handshake              payload
//   input    in         in_valid_i/in_stall_o  in_data_i  (stt_in_t)
//   output   out        out_valid_o/out_stall_i out_data_o (stt_out_t)
//
// One byte is accepted each cycle while the group queue has room.
// Results leave one per cycle from the output register while out_stall_i is low, so an
// item with several results holds the output until all have left; the four-group queue
// absorbs such bursts. A result passes the group queue, the current-group register and
// the output register. Reset is asynchronous and needs no clearing pass.
module source_text_tokenizer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  stt_pkg::stt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output stt_pkg::stt_out_t out_data_o
);

  logic                accept;
  logic                push;
  stt_pkg::stt_group_t push_data;
  logic                q_full;
  logic                pop;
  logic                q_valid;
  stt_pkg::stt_group_t q_data;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  stt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data)
  );

  stt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  stt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for source_text_tokenizer: feeds directed and random source text,
// predicts each result item in step with the accepted bytes and checks the output stream.
// Depends on stt_pkg and the source_text_tokenizer RTL.
module testbench;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_BYTES = 215;

  localparam stt_pkg::tt_t TT_KW_PRINT  = 6'd20;
  localparam stt_pkg::tt_t TT_KW_DO     = 6'd21;
  localparam stt_pkg::tt_t TT_KW_END    = 6'd22;
  localparam stt_pkg::tt_t TT_KW_LET    = 6'd23;
  localparam stt_pkg::tt_t TT_KW_AND    = 6'd25;
  localparam stt_pkg::tt_t TT_KW_OR     = 6'd26;
  localparam stt_pkg::tt_t TT_KW_NULL   = 6'd27;
  localparam stt_pkg::tt_t TT_KW_IF     = 6'd28;
  localparam stt_pkg::tt_t TT_KW_ELSE   = 6'd29;
  localparam stt_pkg::tt_t TT_KW_ELSEIF = 6'd30;
  localparam stt_pkg::tt_t TT_KW_THEN   = 6'd31;
  localparam stt_pkg::tt_t TT_KW_WHILE  = 6'd32;
  localparam stt_pkg::tt_t TT_KW_FN     = 6'd33;
  localparam stt_pkg::tt_t TT_KW_RETURN = 6'd34;

  localparam logic [7:0] CH_VTAB = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;

  string kw_words [16] = '{"print", "do", "end", "let", "true", "false", "and", "or",
                           "null", "if", "else", "elseif", "then", "while", "fn", "return"};
  stt_pkg::tt_t kw_codes [16] = '{TT_KW_PRINT, TT_KW_DO, TT_KW_END, TT_KW_LET,
                                  stt_pkg::TT_BOOLEAN, stt_pkg::TT_BOOLEAN, TT_KW_AND,
                                  TT_KW_OR, TT_KW_NULL, TT_KW_IF, TT_KW_ELSE, TT_KW_ELSEIF,
                                  TT_KW_THEN, TT_KW_WHILE, TT_KW_FN, TT_KW_RETURN};
  logic [7:0] space_chars [6] = '{stt_pkg::CH_SPACE, stt_pkg::CH_TAB, stt_pkg::CH_NEWLINE,
                                  CH_VTAB, CH_FF, stt_pkg::CH_CR};
  logic [7:0] op_chars [13] = '{stt_pkg::CH_PLUS, stt_pkg::CH_STAR, stt_pkg::CH_MINUS,
                                stt_pkg::CH_SLASH, stt_pkg::CH_PERCENT, stt_pkg::CH_LPAREN,
                                stt_pkg::CH_RPAREN, stt_pkg::CH_SEMI, stt_pkg::CH_COMMA,
                                stt_pkg::CH_EQ, stt_pkg::CH_GT, stt_pkg::CH_LT,
                                stt_pkg::CH_BANG};

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  stt_pkg::stt_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  stt_pkg::stt_out_t out_data;

  source_text_tokenizer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #1 clk = ~clk;

  stt_pkg::stt_in_t  pending_bytes [$];
  stt_pkg::stt_out_t predicted_tokens [$];
  logic [7:0]        text_buf [$];
  int unsigned       bytes_taken = 0;
  int unsigned       bytes_total = 0;
  int unsigned       n_fail      = 0;

  // Tokenizer state as predicted
  stt_pkg::mode_e    scan_st;
  stt_pkg::pend_e    op_held;
  logic [7:0]        word_bytes [stt_pkg::KW_MAX_LEN];
  int unsigned       word_len;
  bit                discard;
  bit                err_seen;
  stt_pkg::stt_out_t step_res [stt_pkg::MAX_RES];
  int unsigned       step_n;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == stt_pkg::CH_SPACE || (c >= stt_pkg::CH_TAB && c <= stt_pkg::CH_CR);
  endfunction

  function automatic void add_res(stt_pkg::kind_e k, logic [7:0] b, stt_pkg::tt_t t,
                                  logic bv, logic ec);
    if (step_n < stt_pkg::MAX_RES) begin
      step_res[step_n] = '{kind: k, byte_value: b, tok_id: t, bool_value: bv,
                           error_code: ec, last: 1'b0};
      step_n++;
    end
  endfunction

  function automatic void raise_err(logic [7:0] b, logic ec);
    add_res(stt_pkg::KIND_ERROR, b, stt_pkg::TT_IDENT, 1'b0, ec);
    err_seen = 1'b1;
  endfunction

  function automatic void close_word();
    string        w;
    stt_pkg::tt_t t;
    logic         bv;
    w  = "";
    t  = stt_pkg::TT_IDENT;
    bv = 1'b0;
    if (word_len <= stt_pkg::KW_MAX_LEN) begin
      for (int i = 0; i < word_len; i++) w = $sformatf("%s%c", w, word_bytes[i]);
      foreach (kw_words[k]) begin
        if (t == stt_pkg::TT_IDENT && w == kw_words[k]) begin
          t  = kw_codes[k];
          bv = (w == "true");
        end
      end
    end
    add_res(stt_pkg::KIND_END, 8'h00, t, bv, 1'b0);
  endfunction

  function automatic void clear_state();
    scan_st  = stt_pkg::MODE_IDLE;
    op_held  = stt_pkg::PEND_EQ;
    word_len = 0;
    discard  = 1'b0;
    foreach (word_bytes[i]) word_bytes[i] = 8'h00;
  endfunction

  function automatic void scan_char(logic [7:0] c);
    case (scan_st)
      stt_pkg::MODE_OP: begin
        scan_st = stt_pkg::MODE_IDLE;
        if (c == stt_pkg::CH_EQ) begin
          add_res(stt_pkg::KIND_END, 8'h00,
                  stt_pkg::tt_t'(stt_pkg::TT_EQ + 2 * op_held + 1), 1'b0, 1'b0);
          op_held = stt_pkg::PEND_EQ;
          return;
        end
        add_res(stt_pkg::KIND_END, 8'h00,
                stt_pkg::tt_t'(stt_pkg::TT_EQ + 2 * op_held), 1'b0, 1'b0);
        op_held = stt_pkg::PEND_EQ;
      end
      stt_pkg::MODE_INT, stt_pkg::MODE_FRAC: begin
        if (is_digit(c)) begin
          add_res(stt_pkg::KIND_BYTE, c, stt_pkg::TT_IDENT, 1'b0, 1'b0);
          return;
        end
        if (c == stt_pkg::CH_DOT && scan_st == stt_pkg::MODE_INT) begin
          add_res(stt_pkg::KIND_BYTE, c, stt_pkg::TT_IDENT, 1'b0, 1'b0);
          scan_st = stt_pkg::MODE_FRAC;
          return;
        end
        add_res(stt_pkg::KIND_END, 8'h00, stt_pkg::TT_NUMBER, 1'b0, 1'b0);
        scan_st = stt_pkg::MODE_IDLE;
      end
      stt_pkg::MODE_WORD: begin
        if (is_alpha(c) || is_digit(c) || c == stt_pkg::CH_UNDER) begin
          if (word_len < stt_pkg::KW_MAX_LEN) word_bytes[word_len] = c;
          // saturate one past the keyword limit: too long for any keyword
          if (word_len <= stt_pkg::KW_MAX_LEN) word_len++;
          add_res(stt_pkg::KIND_BYTE, c, stt_pkg::TT_IDENT, 1'b0, 1'b0);
          return;
        end
        close_word();
        scan_st  = stt_pkg::MODE_IDLE;
        word_len = 0;
      end
      stt_pkg::MODE_STRING: begin
        if (c == stt_pkg::CH_QUOTE) begin
          add_res(stt_pkg::KIND_END, 8'h00, stt_pkg::TT_STRING, 1'b0, 1'b0);
          scan_st = stt_pkg::MODE_IDLE;
        end else if (c == stt_pkg::CH_NEWLINE) begin
          raise_err(8'h00, stt_pkg::ERR_UNTERMINATED);
        end else begin
          add_res(stt_pkg::KIND_BYTE, c, stt_pkg::TT_IDENT, 1'b0, 1'b0);
        end
        return;
      end
      default: ;
    endcase

    // rescan the byte from idle
    if (is_space(c)) return;
    case (c)
      stt_pkg::CH_PLUS:    add_res(stt_pkg::KIND_END, 8'h00, stt_pkg::TT_PLUS, 1'b0, 1'b0);
      stt_pkg::CH_STAR:    add_res(stt_pkg::KIND_END, 8'h00, stt_pkg::TT_STAR, 1'b0, 1'b0);
      stt_pkg::CH_MINUS:   add_res(stt_pkg::KIND_END, 8'h00, stt_pkg::TT_MINUS, 1'b0, 1'b0);
      stt_pkg::CH_SLASH:   add_res(stt_pkg::KIND_END, 8'h00, stt_pkg::TT_SLASH, 1'b0, 1'b0);
      stt_pkg::CH_PERCENT: add_res(stt_pkg::KIND_END, 8'h00, stt_pkg::TT_PERCENT, 1'b0, 1'b0);
      stt_pkg::CH_LPAREN:  add_res(stt_pkg::KIND_END, 8'h00, stt_pkg::TT_LPAREN, 1'b0, 1'b0);
      stt_pkg::CH_RPAREN:  add_res(stt_pkg::KIND_END, 8'h00, stt_pkg::TT_RPAREN, 1'b0, 1'b0);
      stt_pkg::CH_SEMI:    add_res(stt_pkg::KIND_END, 8'h00, stt_pkg::TT_SEMI, 1'b0, 1'b0);
      stt_pkg::CH_COMMA:   add_res(stt_pkg::KIND_END, 8'h00, stt_pkg::TT_COMMA, 1'b0, 1'b0);
      stt_pkg::CH_EQ: begin
        scan_st = stt_pkg::MODE_OP;
        op_held = stt_pkg::PEND_EQ;
      end
      stt_pkg::CH_GT: begin
        scan_st = stt_pkg::MODE_OP;
        op_held = stt_pkg::PEND_GT;
      end
      stt_pkg::CH_LT: begin
        scan_st = stt_pkg::MODE_OP;
        op_held = stt_pkg::PEND_LT;
      end
      stt_pkg::CH_BANG: begin
        scan_st = stt_pkg::MODE_OP;
        op_held = stt_pkg::PEND_BANG;
      end
      stt_pkg::CH_QUOTE: scan_st = stt_pkg::MODE_STRING;
      default: begin
        if (is_digit(c)) begin
          add_res(stt_pkg::KIND_BYTE, c, stt_pkg::TT_IDENT, 1'b0, 1'b0);
          scan_st = stt_pkg::MODE_INT;
        end else if (is_alpha(c)) begin
          word_bytes[0] = c;
          word_len      = 1;
          add_res(stt_pkg::KIND_BYTE, c, stt_pkg::TT_IDENT, 1'b0, 1'b0);
          scan_st = stt_pkg::MODE_WORD;
        end else begin
          raise_err(c, stt_pkg::ERR_UNSUPPORTED);
        end
      end
    endcase
  endfunction

  function automatic void flush_text();
    case (scan_st)
      stt_pkg::MODE_OP:
        add_res(stt_pkg::KIND_END, 8'h00,
                stt_pkg::tt_t'(stt_pkg::TT_EQ + 2 * op_held), 1'b0, 1'b0);
      stt_pkg::MODE_INT, stt_pkg::MODE_FRAC:
        add_res(stt_pkg::KIND_END, 8'h00, stt_pkg::TT_NUMBER, 1'b0, 1'b0);
      stt_pkg::MODE_WORD:   close_word();
      stt_pkg::MODE_STRING: raise_err(8'h00, stt_pkg::ERR_UNTERMINATED);
      default: ;
    endcase
  endfunction

  // Advance the predicted state by one byte and queue the tokens it yields.
  function automatic void tokenize_byte(stt_pkg::stt_in_t it);
    step_n   = 0;
    err_seen = 1'b0;
    if (!discard) begin
      scan_char(it.char_byte);
      if (err_seen) discard = 1'b1;
      else if (it.end_of_text) flush_text();
    end
    if (it.end_of_text) clear_state();
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) predicted_tokens.push_back(step_res[i]);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  function automatic int unsigned idle_len(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Stimulus building
  task automatic add_chr(logic [7:0] c);
    text_buf.push_back(c);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // Queue the text, marking its last byte as end of text.
  task automatic send_text();
    stt_pkg::stt_in_t it;
    foreach (text_buf[i]) begin
      it.char_byte   = text_buf[i];
      it.end_of_text = (i == text_buf.size() - 1);
      pending_bytes.push_back(it);
    end
    text_buf.delete();
  endtask

  function automatic logic [7:0] word_char(bit first);
    int unsigned r;
    r = first ? 0 : $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 1) ? 8'($urandom_range("A", "Z"))
                                           : 8'($urandom_range("a", "z"));
    if (r < 9) return 8'($urandom_range("0", "9"));
    return stt_pkg::CH_UNDER;
  endfunction

  task automatic add_token();
    int unsigned sel;
    int unsigned n;
    int unsigned idx;
    logic [7:0]  c;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      add_str(kw_words[$urandom_range(0, 15)]);
    end else if (sel < 40) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
      add_chr(word_char(1'b1));
      repeat (n - 1) add_chr(word_char(1'b0));
    end else if (sel < 55) begin
      repeat ($urandom_range(1, 4)) add_chr(8'($urandom_range("0", "9")));
      if ($urandom_range(0, 1)) begin
        add_chr(stt_pkg::CH_DOT);
        repeat ($urandom_range(0, 3)) add_chr(8'($urandom_range("0", "9")));
      end
    end else if (sel < 67) begin
      add_chr(stt_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 5)) begin
        c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                         : 8'($urandom_range(32, 126));
        if (c == stt_pkg::CH_QUOTE) c = stt_pkg::CH_UNDER;
        add_chr(c);
      end
      // mostly closed; now and then broken by a newline or left open
      n = $urandom_range(0, 19);
      if (n == 0) add_chr(stt_pkg::CH_NEWLINE);
      else if (n != 1) add_chr(stt_pkg::CH_QUOTE);
    end else begin
      idx = $urandom_range(0, 12);
      add_chr(op_chars[idx]);
      if (op_chars[idx] inside {stt_pkg::CH_EQ, stt_pkg::CH_GT, stt_pkg::CH_LT,
                                stt_pkg::CH_BANG} && $urandom_range(0, 1))
        add_chr(stt_pkg::CH_EQ);
    end
  endtask

  task automatic add_random_text();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 9) >= 2) add_chr(space_chars[$urandom_range(0, 5)]);
      if ($urandom_range(0, 9) == 0) add_chr(space_chars[$urandom_range(0, 5)]);
      if ($urandom_range(0, 19) == 0) add_chr(8'($urandom_range(0, 255)));
      else add_token();
    end
    send_text();
  endtask

  // Driver: hold the item while stalled, then advance after an optional gap.
  int unsigned send_gap   = 0;
  int unsigned send_phase = 0;
  bit          send_calm  = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tokenize_byte(in_data);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_data  <= pending_bytes.pop_front();
          in_valid <= 1'b1;
          send_gap = idle_len(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (send_phase == 0) begin
        send_calm  = !send_calm;
        send_phase = $urandom_range(20, 80);
      end else begin
        send_phase--;
      end
    end
  end

  // Monitor: compare each accepted result item with the oldest prediction.
  int unsigned       stall_left = 0;
  int unsigned       recv_phase = 0;
  bit                recv_calm  = 1'b0;
  stt_pkg::stt_out_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (predicted_tokens.size() == 0) begin
          $error("unexpected result: kind %0d byte %0d tok_id %0d",
                 out_data.kind, out_data.byte_value, out_data.tok_id);
          n_fail++;
        end else begin
          want = predicted_tokens.pop_front();
          check_field("kind", want.kind, out_data.kind);
          check_field("byte_value", want.byte_value, out_data.byte_value);
          check_field("tok_id", want.tok_id, out_data.tok_id);
          check_field("bool_value", want.bool_value, out_data.bool_value);
          check_field("error_code", want.error_code, out_data.error_code);
          check_field("last", want.last, out_data.last);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = idle_len(recv_calm);
      end
      if (recv_phase == 0) begin
        recv_calm  = !recv_calm;
        recv_phase = $urandom_range(20, 80);
      end else begin
        recv_phase--;
      end
    end
  end

  // Watchdog: end the run when neither side accepts anything for too long.
  int unsigned quiet = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    clear_state();
    // lookahead, fraction, operator flushed at end of text
    add_str("x<=1.5!");
    send_text();
    // newline inside a string, then discard to end of text
    add_str("\"s\nq");
    send_text();
    add_chr(8'hFF);
    send_text();
    add_chr(8'h00);
    send_text();
    // over-long word that starts like a keyword, ended by punctuation
    add_str("elseif7x)");
    send_text();
    // string still open at end of text
    add_str("\"ab");
    send_text();
    while (pending_bytes.size() < RANDOM_BYTES) add_random_text();
    bytes_total = pending_bytes.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (bytes_taken < bytes_total) @(posedge clk);
    while (predicted_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
